### hdl/lbm_pkg.sv
`default_nettype none
package lbm_pkg;

   localparam int LABEL_BITS     = 16;
   localparam int VALUE_BITS     = 16;
   localparam int MAX_SLICES     = 256;
   localparam int Z_BITS         = $clog2(MAX_SLICES + 1);
   localparam int DEF_MAX_WIDTH  = 128;
   localparam int DEF_MAX_HEIGHT = 128;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;

   localparam int FRAME_WIDTH_RESET  = 128;
   localparam int FRAME_HEIGHT_RESET = 128;
   localparam int SLICE_COUNT_RESET  = 1;
   localparam int BORDER_VALUE_RESET = 65535;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_FRAME_WIDTH,
      CSR_FRAME_HEIGHT,
      CSR_SLICE_COUNT,
      CSR_VOLUME_MODE,
      CSR_MARK_MARGINS,
      CSR_BORDER_VALUE
   } csr_index_type;

   typedef enum logic {
      CMD_PIXEL,
      CMD_FLUSH
   } cmd_type;

   typedef struct packed {
      cmd_type               cmd;
      logic [LABEL_BITS-1:0] label_value;
      logic [VALUE_BITS-1:0] pixel_value;
   } req_type;

   typedef struct packed {
      logic [VALUE_BITS-1:0] out_value;
      logic                  is_border;
      logic                  frame_last;
   } rsp_type;

   // per-word control from the sequencer to the window
   typedef struct packed {
      logic shift;
      logic emit;
      logic left_ok;
      logic right_ok;
      logic up_ok;
      logic down_ok;
      logic back_ok;
      logic front_ok;
      logic edge_hit;
      logic last;
   } ctl_type;

   function automatic int unsigned clamp_u(input int unsigned v, input int unsigned hi);
      int unsigned r;
      if (v < 1) r = 1;
      else if (v > hi) r = hi;
      else r = v;
      return r;
   endfunction

endpackage
`default_nettype wire

### hdl/lbm_ram.sv
`default_nettype none
module lbm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 128,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

### hdl/lbm_delay.sv
`default_nettype none
// circular delay of run-time length, advanced by shift; output is the word
// written len shifts ago, or the input itself when len is zero
module lbm_delay #(
   parameter int WIDTH    = 16,
   parameter int DEPTH    = 128,
   localparam int LEN_BITS = $clog2(DEPTH + 1),
   localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                shift,
   input  wire logic [LEN_BITS-1:0] len,
   input  wire logic [WIDTH-1:0]    din,
   output logic      [WIDTH-1:0]    dout
);

   logic [AW-1:0]       ptr_ff, ptr_in, ptr_cur;
   logic [LEN_BITS-1:0] ptr_inc;
   logic                fwd_ff, fwd_in;
   logic [WIDTH-1:0]    fwd_data_ff;
   logic [WIDTH-1:0]    rd_data;

   always_comb begin
      // a pointer left beyond a shorter length restarts at the bottom
      ptr_cur = (LEN_BITS'(ptr_ff) >= len) ? '0 : ptr_ff;
      ptr_inc = LEN_BITS'(ptr_cur) + 1'b1;
      ptr_in  = ptr_cur;
      if (shift) begin
         ptr_in = (ptr_inc >= len) ? '0 : AW'(ptr_inc);
      end
      // a length of one reads back the entry being written
      fwd_in = shift && (ptr_in == ptr_cur);
   end

   lbm_ram #(
      .WIDTH (WIDTH),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (shift && (len != '0)),
      .wr_addr (ptr_cur),
      .wr_data (din),
      .rd_addr (ptr_in),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff <= '0;
         fwd_ff <= 1'b0;
      end else begin
         ptr_ff <= ptr_in;
         fwd_ff <= fwd_in;
      end
      fwd_data_ff <= din;
   end

   always_comb begin
      if (len == '0) dout = din;
      else if (fwd_ff) dout = fwd_data_ff;
      else dout = rd_data;
   end

endmodule
`default_nettype wire

### hdl/lbm_ctrl.sv
`default_nettype none
module lbm_ctrl
   import lbm_pkg::*;
#(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
   localparam int W_BITS  = $clog2(MAX_WIDTH + 1),
   localparam int H_BITS  = $clog2(MAX_HEIGHT + 1),
   localparam int WH_BITS = $clog2(MAX_WIDTH * MAX_HEIGHT + 1)
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               accept,
   input  wire cmd_type            cmd,
   input  wire logic [W_BITS-1:0]  w,
   input  wire logic [H_BITS-1:0]  h,
   input  wire logic [Z_BITS-1:0]  zs,
   input  wire logic               vol,
   input  wire logic [WH_BITS-1:0] d,
   output ctl_type                 ctl
);

   logic [W_BITS-1:0]  ix_ff, ix_in, ox_ff, ox_in;
   logic [H_BITS-1:0]  iy_ff, iy_in, oy_ff, oy_in;
   logic [Z_BITS-1:0]  iz_ff, iz_in, oz_ff, oz_in;
   logic [WH_BITS-1:0] lag_ff, lag_in;
   logic               full, store, emit, last;
   logic               z_first, z_final;

   always_comb begin
      full  = (iz_ff >= zs);
      store = accept && (cmd == CMD_PIXEL) && !full;
      // words pending between input and output; a pixel releases one once
      // the whole neighbourhood is in, a flush only after the frame is full
      emit  = accept && (store ? (lag_ff >= d) : full);

      ix_in  = ix_ff;
      iy_in  = iy_ff;
      iz_in  = iz_ff;
      ox_in  = ox_ff;
      oy_in  = oy_ff;
      oz_in  = oz_ff;
      lag_in = lag_ff;

      if (store) begin
         ix_in = ix_ff + 1'b1;
         if (ix_in >= w) begin
            ix_in = '0;
            iy_in = iy_ff + 1'b1;
         end
         if (iy_in >= h) begin
            iy_in = '0;
            iz_in = iz_ff + 1'b1;
         end
      end

      if (emit) begin
         ox_in = ox_ff + 1'b1;
         if (ox_in >= w) begin
            ox_in = '0;
            oy_in = oy_ff + 1'b1;
         end
         if (oy_in >= h) begin
            oy_in = '0;
            oz_in = oz_ff + 1'b1;
         end
      end
      last = emit && (oz_in >= zs);

      if (store && !emit) lag_in = lag_ff + 1'b1;
      else if (!store && emit) lag_in = lag_ff - 1'b1;

      if (last) begin
         ix_in  = '0;
         iy_in  = '0;
         iz_in  = '0;
         ox_in  = '0;
         oy_in  = '0;
         oz_in  = '0;
         lag_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ix_ff  <= '0;
         iy_ff  <= '0;
         iz_ff  <= '0;
         ox_ff  <= '0;
         oy_ff  <= '0;
         oz_ff  <= '0;
         lag_ff <= '0;
      end else begin
         ix_ff  <= ix_in;
         iy_ff  <= iy_in;
         iz_ff  <= iz_in;
         ox_ff  <= ox_in;
         oy_ff  <= oy_in;
         oz_ff  <= oz_in;
         lag_ff <= lag_in;
      end
   end

   always_comb begin
      z_first      = (oz_ff == '0);
      z_final      = !((oz_ff + 1'b1) < zs);
      ctl.shift    = store || emit;
      ctl.emit     = emit;
      ctl.left_ok  = (ox_ff != '0);
      ctl.right_ok = ((ox_ff + 1'b1) < w);
      ctl.up_ok    = (oy_ff != '0);
      ctl.down_ok  = ((oy_ff + 1'b1) < h);
      ctl.back_ok  = vol && !z_first;
      ctl.front_ok = vol && !z_final;
      ctl.edge_hit = !ctl.left_ok || !ctl.right_ok || !ctl.up_ok || !ctl.down_ok
                     || (vol && (z_first || z_final));
      ctl.last     = last;
   end

endmodule
`default_nettype wire

### hdl/lbm_window.sv
`default_nettype none
// label tap chain and image delay line; each label delay stage outputs one
// neighbour of the pending pixel
module lbm_window
   import lbm_pkg::*;
#(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
   localparam int OUTER_DEPTH = MAX_WIDTH * (MAX_HEIGHT - 1),
   localparam int ROW_DEPTH   = MAX_WIDTH - 1,
   localparam int VAL_DEPTH   = MAX_WIDTH * MAX_HEIGHT,
   localparam int LA_BITS     = $clog2(OUTER_DEPTH + 1),
   localparam int LB_BITS     = $clog2(ROW_DEPTH + 1),
   localparam int WH_BITS     = $clog2(VAL_DEPTH + 1)
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire ctl_type               ctl,
   input  wire logic [LABEL_BITS-1:0] label_in,
   input  wire logic [VALUE_BITS-1:0] pixel_in,
   input  wire logic [LA_BITS-1:0]    len_outer,
   input  wire logic [LB_BITS-1:0]    len_row,
   input  wire logic [WH_BITS-1:0]    len_value,
   input  wire logic                  mark,
   input  wire logic [VALUE_BITS-1:0] mark_value,
   output rsp_type                    word
);

   logic [LABEL_BITS-1:0] down_lab, right_lab, up_lab, back_lab;
   logic [LABEL_BITS-1:0] me_ff, left_ff;
   logic [VALUE_BITS-1:0] value_out;
   logic                  greater, border;

   // incoming word is the front neighbour in volumes, the lower one in planes
   lbm_delay #(.WIDTH(LABEL_BITS), .DEPTH(OUTER_DEPTH)) u_lower (
      .clock (clock), .reset (reset), .shift (ctl.shift), .len (len_outer),
      .din   (label_in), .dout (down_lab)
   );

   lbm_delay #(.WIDTH(LABEL_BITS), .DEPTH(ROW_DEPTH)) u_right (
      .clock (clock), .reset (reset), .shift (ctl.shift), .len (len_row),
      .din   (down_lab), .dout (right_lab)
   );

   always_ff @(posedge clock) begin
      if (ctl.shift) begin
         me_ff   <= right_lab;
         left_ff <= me_ff;
      end
   end

   lbm_delay #(.WIDTH(LABEL_BITS), .DEPTH(ROW_DEPTH)) u_upper (
      .clock (clock), .reset (reset), .shift (ctl.shift), .len (len_row),
      .din   (left_ff), .dout (up_lab)
   );

   lbm_delay #(.WIDTH(LABEL_BITS), .DEPTH(OUTER_DEPTH)) u_back (
      .clock (clock), .reset (reset), .shift (ctl.shift), .len (len_outer),
      .din   (up_lab), .dout (back_lab)
   );

   lbm_delay #(.WIDTH(VALUE_BITS), .DEPTH(VAL_DEPTH)) u_value (
      .clock (clock), .reset (reset), .shift (ctl.shift), .len (len_value),
      .din   (pixel_in), .dout (value_out)
   );

   always_comb begin
      greater = (ctl.left_ok  && (me_ff > left_ff))
             || (ctl.right_ok && (me_ff > right_lab))
             || (ctl.up_ok    && (me_ff > up_lab))
             || (ctl.down_ok  && (me_ff > down_lab))
             || (ctl.back_ok  && (me_ff > back_lab))
             || (ctl.front_ok && (me_ff > label_in));
      border          = greater || (mark && ctl.edge_hit);
      word.out_value  = border ? mark_value : value_out;
      word.is_border  = border;
      word.frame_last = ctl.last;
   end

endmodule
`default_nettype wire

### hdl/label_border_marker_top.sv
`default_nettype none
// label border marker
// req channel: one word per pixel in raster order (x, then y, then z) carrying
// a label and an image value, or a flush word. rsp channel: one word per output
// pixel, the border value where the label exceeds an in-frame neighbour's (or,
// with margin marking, on the frame edge), else the pixel's own image value.
// csr port: plain writes of the frame size, slice count, mode, margin flag
// and border value; write between frames only.
// Throughput is one word per cycle unless the output queue is full: each tap
// is the input, a register or a circular line store read, each store with one
// write and one registered read a cycle. A pixel's result enters the output
// queue as the word completing its neighbourhood is accepted, the pixel one
// row on in planar mode or one slice on in volume mode; with the frame full,
// each flush word releases one pending pixel; frame_last marks the final one.
// Reset clears the counters and output queue and restores the register
// defaults; line stores are not cleared and no sweep is needed.
// A stalled receiver fills a two-word output queue; req_stall rises only
// while both entries are held.
module label_border_marker_top
   import lbm_pkg::*;
#(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire req_type                   req_data,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output rsp_type                        rsp_data,
   input  wire logic                      csr_we,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam int W_BITS   = $clog2(MAX_WIDTH + 1);
   localparam int H_BITS   = $clog2(MAX_HEIGHT + 1);
   localparam int WH_BITS  = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
   localparam int LA_BITS  = $clog2(MAX_WIDTH * (MAX_HEIGHT - 1) + 1);
   localparam int LB_BITS  = $clog2(MAX_WIDTH);
   localparam int WH_RESET = clamp_u(FRAME_WIDTH_RESET, MAX_WIDTH)
                             * clamp_u(FRAME_HEIGHT_RESET, MAX_HEIGHT);

   logic [7:0]            fw_ff, fh_ff;
   logic [8:0]            sc_ff;
   logic                  vol_ff, mark_ff;
   logic [VALUE_BITS-1:0] bval_ff;
   logic [WH_BITS-1:0]    wh_ff, wh_in;

   logic [W_BITS-1:0]     w_cur, w_sel;
   logic [H_BITS-1:0]     h_cur, h_sel;
   logic [WH_BITS-1:0]    w_ext, h_ext;
   logic [Z_BITS-1:0]     zs;
   logic [WH_BITS-1:0]    d;
   logic [LA_BITS-1:0]    len_outer;
   logic [LB_BITS-1:0]    len_row;

   logic                  accept;
   ctl_type               ctl;
   rsp_type               word;

   rsp_type               q0_ff, q0_in, q1_ff, q1_in;
   logic [1:0]            cnt_ff, cnt_in, slot;
   logic                  push, pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         fw_ff   <= 8'(FRAME_WIDTH_RESET);
         fh_ff   <= 8'(FRAME_HEIGHT_RESET);
         sc_ff   <= 9'(SLICE_COUNT_RESET);
         vol_ff  <= 1'b0;
         mark_ff <= 1'b0;
         bval_ff <= VALUE_BITS'(BORDER_VALUE_RESET);
         wh_ff   <= WH_BITS'(WH_RESET);
      end else begin
         wh_ff <= wh_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_FRAME_WIDTH:  fw_ff   <= csr_wdata[7:0];
               CSR_FRAME_HEIGHT: fh_ff   <= csr_wdata[7:0];
               CSR_SLICE_COUNT:  sc_ff   <= csr_wdata[8:0];
               CSR_VOLUME_MODE:  vol_ff  <= csr_wdata[0];
               CSR_MARK_MARGINS: mark_ff <= csr_wdata[0];
               CSR_BORDER_VALUE: bval_ff <= csr_wdata[VALUE_BITS-1:0];
               default: ;
            endcase
         end
      end
   end

   always_comb begin
      w_cur = W_BITS'(clamp_u(32'(fw_ff), MAX_WIDTH));
      h_cur = H_BITS'(clamp_u(32'(fh_ff), MAX_HEIGHT));
      w_sel = w_cur;
      h_sel = h_cur;
      // area follows a size write in the same cycle
      if (csr_we && (csr_index == CSR_FRAME_WIDTH)) begin
         w_sel = W_BITS'(clamp_u(32'(csr_wdata[7:0]), MAX_WIDTH));
      end
      if (csr_we && (csr_index == CSR_FRAME_HEIGHT)) begin
         h_sel = H_BITS'(clamp_u(32'(csr_wdata[7:0]), MAX_HEIGHT));
      end
      w_ext = WH_BITS'(w_sel);
      h_ext = WH_BITS'(h_sel);
      wh_in = w_ext * h_ext;

      zs        = vol_ff ? Z_BITS'(clamp_u(32'(sc_ff), MAX_SLICES)) : Z_BITS'(1);
      d         = vol_ff ? wh_ff : WH_BITS'(w_cur);
      len_outer = vol_ff ? LA_BITS'(wh_ff - WH_BITS'(w_cur)) : '0;
      len_row   = LB_BITS'(w_cur - 1'b1);
   end

   assign req_stall = (cnt_ff == 2'd2);
   assign accept    = req_valid && !req_stall;

   lbm_ctrl #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .cmd    (req_data.cmd),
      .w      (w_cur),
      .h      (h_cur),
      .zs     (zs),
      .vol    (vol_ff),
      .d      (d),
      .ctl    (ctl)
   );

   lbm_window #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_window (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .label_in   (req_data.label_value),
      .pixel_in   (req_data.pixel_value),
      .len_outer  (len_outer),
      .len_row    (len_row),
      .len_value  (d),
      .mark       (mark_ff),
      .mark_value (bval_ff),
      .word       (word)
   );

   // two-entry output queue, head in q0
   always_comb begin
      push   = ctl.emit;
      pop    = (cnt_ff != 2'd0) && !rsp_stall;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
      slot   = cnt_ff - {1'b0, pop};
      q0_in  = q0_ff;
      q1_in  = q1_ff;
      if (pop) q0_in = q1_ff;
      if (push) begin
         if (slot == 2'd0) q0_in = word;
         else q1_in = word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
      q0_ff <= q0_in;
      q1_ff <= q1_in;
   end

   assign rsp_valid = (cnt_ff != 2'd0);
   assign rsp_data  = q0_ff;

endmodule
`default_nettype wire

### hdl/lbm_checker.sv
`default_nettype none
module lbm_checker
   import lbm_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_stall,
   input wire logic    rsp_valid,
   input wire logic    rsp_stall,
   input wire rsp_type rsp_data
);

   // a held word stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp word dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_data))
      else $error("rsp word changed while stalled");

   // queue and stall state clear after reset
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("output not clear after reset");

   // a fresh result needs an accepted word the cycle before
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && rsp_valid && !$past(rsp_valid)
      |-> $past(req_valid && !req_stall))
      else $error("rsp word without accepted input");

   // input is held back only by a full queue
   a_stall_cause: assert property (@(posedge clock)
      req_stall |-> rsp_valid)
      else $error("req stalled with no word waiting");

endmodule

bind label_border_marker_top lbm_checker u_lbm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
`default_nettype wire
